### rtl/twmn_pkg.sv
package twmn_pkg;

	localparam int MAX_NEIGHBORS = 4;
	localparam int NODE_ID_BITS  = 6;
	localparam int VALUE_BITS    = 32;
	localparam int MAX_RESULTS   = 4;

	// register indexes of the configuration port
	localparam logic [2:0] REG_NEIGHBOR_COUNT = 3'd0;
	localparam logic [2:0] REG_NEIGHBOR_ID_A  = 3'd1;
	localparam logic [2:0] REG_NEIGHBOR_ID_B  = 3'd2;
	localparam logic [2:0] REG_NEIGHBOR_ID_C  = 3'd3;
	localparam logic [2:0] REG_NEIGHBOR_ID_D  = 3'd4;
	localparam logic [2:0] REG_OWN_VALUE      = 3'd5;

	// input op codes
	localparam logic OP_START   = 1'b0;
	localparam logic OP_MESSAGE = 1'b1;

	// message kinds
	localparam logic MSG_PRE  = 1'b0;
	localparam logic MSG_POST = 1'b1;

	// result kinds
	localparam logic OUT_MESSAGE = 1'b0;
	localparam logic OUT_REPORT  = 1'b1;

	typedef struct packed {
		logic                         op;
		logic [NODE_ID_BITS-1:0]      source_node;
		logic                         msg_kind;
		logic signed [VALUE_BITS-1:0] msg_value;
	} in_beat_t;

	typedef struct packed {
		logic                         out_kind;
		logic [NODE_ID_BITS-1:0]      dest_node;
		logic                         out_msg_kind;
		logic signed [VALUE_BITS-1:0] out_value;
		logic                         is_decider;
		logic                         last_of_run;
	} out_beat_t;

	// all results of one item, handed from the node logic to the emitter
	typedef struct packed {
		logic                         load;
		logic [2:0]                   count;
		out_beat_t [MAX_RESULTS-1:0]  res;
	} bundle_t;

endpackage

### rtl/twmn_node.sv
module twmn_node (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                msg_valid,
	output logic                msg_stall,
	input  twmn_pkg::in_beat_t  msg_beat,
	input  logic                free,
	output twmn_pkg::bundle_t   bundle
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_GATHER = 2'd1;
	localparam logic [1:0] PH_WAIT   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	localparam int NB = twmn_pkg::MAX_NEIGHBORS;
	localparam int IB = twmn_pkg::NODE_ID_BITS;
	localparam int VB = twmn_pkg::VALUE_BITS;

	// configuration
	logic [2:0]                nbr_count_q;
	logic [IB-1:0]             nbr_id_q [NB];
	logic signed [VB-1:0]      own_value_q;

	// wave state
	logic [1:0]                phase_q, phase_d;
	logic [NB-1:0]             heard_q, heard_d;
	logic [2:0]                heard_cnt_q, heard_cnt_d;
	logic signed [VB-1:0]      min_q, min_d;
	logic                      decider_q, decider_d;

	// input register
	twmn_pkg::in_beat_t        item_s1;
	logic                      item_vld_s1;

	logic                      adv;
	logic [2:0]                n_used;
	logic                      hit;
	logic [1:0]                hit_slot;
	logic [2:0]                nres;
	twmn_pkg::out_beat_t [twmn_pkg::MAX_RESULTS-1:0] res;

	assign adv       = item_vld_s1 && free;
	assign msg_stall = item_vld_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (msg_valid && !msg_stall) begin
			item_vld_s1 <= 1'b1;
		end else if (adv) begin
			item_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (msg_valid && !msg_stall) begin
			item_s1 <= msg_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbr_count_q <= 3'd1;
			for (int i = 0; i < NB; i++) nbr_id_q[i] <= '0;
			own_value_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				twmn_pkg::REG_NEIGHBOR_COUNT: nbr_count_q <= cfg_data[2:0];
				twmn_pkg::REG_NEIGHBOR_ID_A:  nbr_id_q[0] <= cfg_data[IB-1:0];
				twmn_pkg::REG_NEIGHBOR_ID_B:  nbr_id_q[1] <= cfg_data[IB-1:0];
				twmn_pkg::REG_NEIGHBOR_ID_C:  nbr_id_q[2] <= cfg_data[IB-1:0];
				twmn_pkg::REG_NEIGHBOR_ID_D:  nbr_id_q[3] <= cfg_data[IB-1:0];
				twmn_pkg::REG_OWN_VALUE:      own_value_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// count clamped into 1..MAX_NEIGHBORS
	always_comb begin
		if (nbr_count_q == 3'd0) n_used = 3'd1;
		else if (nbr_count_q > 3'(NB)) n_used = 3'(NB);
		else n_used = nbr_count_q;
	end

	// first slot in use whose id matches the sender
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = NB - 1; i >= 0; i--) begin
			if (3'(i) < n_used && nbr_id_q[i] == item_s1.source_node) begin
				hit      = 1'b1;
				hit_slot = 2'(i);
			end
		end
	end

	always_comb begin
		logic [1:0] sel;
		logic [2:0] k;
		phase_d     = phase_q;
		heard_d     = heard_q;
		heard_cnt_d = heard_cnt_q;
		min_d       = min_q;
		decider_d   = decider_q;
		nres        = 3'd0;
		res         = '0;
		sel         = '0;
		k           = '0;
		if (item_s1.op == twmn_pkg::OP_START) begin
			heard_d     = '0;
			heard_cnt_d = '0;
			min_d       = own_value_q;
			decider_d   = 1'b0;
			phase_d     = PH_GATHER;
			if (n_used == 3'd1) begin
				res[0].out_kind     = twmn_pkg::OUT_MESSAGE;
				res[0].dest_node    = nbr_id_q[0];
				res[0].out_msg_kind = twmn_pkg::MSG_PRE;
				res[0].out_value    = own_value_q;
				nres                = 3'd1;
				phase_d             = PH_WAIT;
			end
		end else begin
			case (phase_q)
				PH_GATHER: begin
					if (item_s1.msg_kind == twmn_pkg::MSG_PRE) begin
						heard_cnt_d = heard_cnt_q + 3'd1;
						if (hit) heard_d[hit_slot] = 1'b1;
						if (item_s1.msg_value < min_q) min_d = item_s1.msg_value;
						if (heard_cnt_d >= n_used - 3'd1) begin
							// first unheard slot, else the last slot in use
							sel = 2'(n_used - 3'd1);
							for (int i = NB - 1; i >= 0; i--) begin
								if (3'(i) < n_used && !heard_d[i]) sel = 2'(i);
							end
							res[0].out_kind     = twmn_pkg::OUT_MESSAGE;
							res[0].dest_node    = nbr_id_q[sel];
							res[0].out_msg_kind = twmn_pkg::MSG_PRE;
							res[0].out_value    = min_d;
							nres                = 3'd1;
							phase_d             = PH_WAIT;
						end
					end
				end
				PH_WAIT: begin
					if (hit) begin
						if (item_s1.msg_kind == twmn_pkg::MSG_PRE) begin
							heard_cnt_d       = heard_cnt_q + 3'd1;
							heard_d[hit_slot] = 1'b1;
							decider_d         = 1'b1;
						end
						if (item_s1.msg_value < min_q) min_d = item_s1.msg_value;
						for (int i = 0; i < NB; i++) begin
							if (3'(i) < n_used && nbr_id_q[i] != item_s1.source_node) begin
								res[k[1:0]].out_kind     = twmn_pkg::OUT_MESSAGE;
								res[k[1:0]].dest_node    = nbr_id_q[i];
								res[k[1:0]].out_msg_kind = twmn_pkg::MSG_POST;
								res[k[1:0]].out_value    = min_d;
								k = k + 3'd1;
							end
						end
						res[k[1:0]].out_kind   = twmn_pkg::OUT_REPORT;
						res[k[1:0]].out_value  = min_d;
						res[k[1:0]].is_decider = decider_d;
						nres    = k + 3'd1;
						phase_d = PH_DONE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			heard_q     <= '0;
			heard_cnt_q <= '0;
			min_q       <= '0;
			decider_q   <= 1'b0;
		end else if (adv) begin
			phase_q     <= phase_d;
			heard_q     <= heard_d;
			heard_cnt_q <= heard_cnt_d;
			min_q       <= min_d;
			decider_q   <= decider_d;
		end
	end

	assign bundle.load  = adv;
	assign bundle.count = nres;
	assign bundle.res   = res;

`ifndef NO_ASSERTIONS
	a_wait_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.op == twmn_pkg::OP_MESSAGE && phase_q == PH_WAIT && hit)
		|=> phase_q == PH_DONE)
		else $error("wave did not finish on a known sender while waiting");
	a_decider_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		decider_q |-> phase_q == PH_DONE)
		else $error("decider flag outside done phase");
`endif

endmodule

### rtl/twmn_emit.sv
module twmn_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  twmn_pkg::bundle_t   bundle,
	output logic                free,
	output logic                res_valid,
	input  logic                res_stall,
	output twmn_pkg::out_beat_t res_beat
);

	twmn_pkg::out_beat_t [twmn_pkg::MAX_RESULTS-1:0] res_q;
	logic [2:0]  cnt_q;
	logic [1:0]  idx_q;
	logic        last;
	logic        take;

	assign res_valid = cnt_q != 3'd0;
	assign last      = {1'b0, idx_q} == cnt_q - 3'd1;
	assign take      = res_valid && !res_stall;
	assign free      = !res_valid || (take && last);

	always_comb begin
		res_beat             = res_q[idx_q];
		res_beat.last_of_run = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (free) begin
			cnt_q <= bundle.load ? bundle.count : 3'd0;
			idx_q <= '0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && bundle.load) begin
			res_q <= bundle.res;
		end
	end

`ifndef NO_ASSERTIONS
	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> {1'b0, idx_q} < cnt_q)
		else $error("result index beyond run length");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(twmn_pkg::MAX_RESULTS))
		else $error("run longer than result buffer");
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last) |=> (res_valid && idx_q == $past(idx_q) + 2'd1))
		else $error("run cut short");
`endif

endmodule

### rtl/tree_wave_min_node_core.sv
// Channel  | Handshake             | Beat                 | Notes
// msg      | msg_valid / msg_stall | twmn_pkg::in_beat_t  | start or incoming message
// res      | res_valid / res_stall | twmn_pkg::out_beat_t | messages, then report
// cfg      | cfg_wr_en             | cfg_index, cfg_data  | write only, no wait
//
// An accepted beat waits in the input register until the result buffer is free, then
// its state update is done and all its results (0 to 4) land in the result buffer.
// Results leave one per cycle while res_stall is low; the buffer takes a new item only
// when empty or as the last result of its run is taken, so it sets the sustained rate.
// The input register takes a new beat while a run still drains.
// arst_n clears the wave state to idle and the registers to their defaults.
// A stalled result holds; msg_stall rises only while the input register waits.
module tree_wave_min_node_core (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	// incoming beats
	input  logic                msg_valid,
	output logic                msg_stall,
	input  twmn_pkg::in_beat_t  msg_beat,
	// result beats
	output logic                res_valid,
	input  logic                res_stall,
	output twmn_pkg::out_beat_t res_beat
);

	twmn_pkg::bundle_t bundle;
	logic              free;

	// node state and per-item decision logic
	twmn_node u_node (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_beat  (msg_beat),
		.free      (free),
		.bundle    (bundle)
	);

	// result buffer, drained one beat per cycle while res_stall is low
	twmn_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat)
	);

`ifndef NO_ASSERTIONS
	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		bundle.load |-> free)
		else $error("item advanced into a busy result buffer");
`endif

endmodule
